### rtl/core/frp_pkg.sv
// Package: shared types, character codes and byte classes of the FASTA record parser.
`timescale 1ns / 1ps
`default_nettype none

package frp_pkg;

    // Characters that steer the parse
    localparam logic [7:0] CH_REC_START = 8'h3E;  // '>'
    localparam logic [7:0] CH_SEMI      = 8'h3B;  // ';'
    localparam logic [7:0] CH_SPACE     = 8'h20;  // ' '
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;  // '\n'
    localparam logic [7:0] CH_DOT       = 8'h2E;  // '.'
    localparam logic [7:0] CH_DASH      = 8'h2D;  // '-'
    localparam logic [7:0] CH_TAB       = 8'h09;  // first control whitespace
    localparam logic [7:0] CH_CR        = 8'h0D;  // last control whitespace
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

    // Result queue size; must hold two results beyond one in flight
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        KIND_ID      = 2'd0,
        KIND_INFO    = 2'd1,
        KIND_COMMENT = 2'd2,
        KIND_SEQ     = 2'd3
    } field_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_START   = 2'd1,
        STATUS_INCOMPLETE = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        ST_SEARCH  = 7'b0000001,
        ST_ID      = 7'b0000010,
        ST_INFO    = 7'b0000100,
        ST_CHECK   = 7'b0001000,
        ST_COMMENT = 7'b0010000,
        ST_SEQ     = 7'b0100000,
        ST_ERROR   = 7'b1000000
    } stage_t;

    typedef struct packed {
        field_kind_t field_kind;
        logic [7:0]  char_out;
        logic        char_valid;
        logic        field_end;
        logic        record_end;
        status_t     status;
        logic        last;
    } result_t;

    localparam result_t RESULT_NONE = '{
        field_kind: KIND_ID, char_out: 8'd0, char_valid: 1'b0,
        field_end: 1'b0, record_end: 1'b0, status: STATUS_OK, last: 1'b0
    };

    function automatic logic is_seq_byte(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               c == CH_DOT || c == CH_DASH;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic result_t make_result(input field_kind_t kind, input logic [7:0] c,
                                            input logic valid, input logic fend,
                                            input logic rend, input status_t st);
        result_t r;
        r.field_kind = kind;
        r.char_out   = valid ? c : 8'd0;
        r.char_valid = valid;
        r.field_end  = fend;
        r.record_end = rend;
        r.status     = st;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/frp_in_if.sv
// Interface: input byte channel of the FASTA record parser.
`timescale 1ns / 1ps
`default_nettype none

interface frp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       stream_end;

    modport source (output valid, output char_in, output stream_end, input ready);
    modport sink   (input valid, input char_in, input stream_end, output ready);
endinterface

`default_nettype wire

### rtl/core/frp_out_if.sv
// Interface: labeled result channel of the FASTA record parser.
`timescale 1ns / 1ps
`default_nettype none

interface frp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] field_kind;
    logic [7:0] char_out;
    logic       char_valid;
    logic       field_end;
    logic       record_end;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output field_kind, output char_out, output char_valid,
                    output field_end, output record_end, output status, output last,
                    input ready);
    modport sink   (input valid, input field_kind, input char_out, input char_valid,
                    input field_end, input record_end, input status, input last,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/frp_parse_fsm.sv
// Module: parse stage register and per-byte classification into up to two results.
`timescale 1ns / 1ps
`default_nettype none

module frp_parse_fsm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      char_in,
    input  wire logic            stream_end,
    output frp_pkg::result_t     res0,
    output frp_pkg::result_t     res1,
    output logic [1:0]           res_cnt
);
    import frp_pkg::*;

    stage_t  stage_reg;
    stage_t  stage_next;
    result_t r0;
    result_t r1;
    logic    is_start;

    assign is_start = (char_in == CH_REC_START) || (char_in == CH_SEMI);

    // Classify the byte against the current stage
    always_comb
    begin
        stage_next = stage_reg;
        r0         = RESULT_NONE;
        r1         = RESULT_NONE;
        res_cnt    = 2'd0;
        if (stage_reg == ST_ERROR)
        begin
            r0      = make_result(KIND_ID, 8'd0, 1'b0, 1'b0, 1'b0, STATUS_NO_START);
            res_cnt = 2'd1;
        end
        else if (stream_end)
        begin
            // Close any open record and return to search
            stage_next = ST_SEARCH;
            case (stage_reg)
                ST_ID:
                begin
                    r0 = make_result(KIND_ID, 8'd0, 1'b0, 1'b1, 1'b1, STATUS_INCOMPLETE);
                    res_cnt = 2'd1;
                end
                ST_INFO:
                begin
                    r0 = make_result(KIND_INFO, 8'd0, 1'b0, 1'b1, 1'b1, STATUS_INCOMPLETE);
                    res_cnt = 2'd1;
                end
                ST_COMMENT:
                begin
                    r0 = make_result(KIND_COMMENT, 8'd0, 1'b0, 1'b1, 1'b1,
                                     STATUS_INCOMPLETE);
                    res_cnt = 2'd1;
                end
                ST_CHECK:
                begin
                    r0 = make_result(KIND_SEQ, 8'd0, 1'b0, 1'b0, 1'b1, STATUS_INCOMPLETE);
                    res_cnt = 2'd1;
                end
                ST_SEQ:
                begin
                    r0 = make_result(KIND_SEQ, 8'd0, 1'b0, 1'b1, 1'b1, STATUS_OK);
                    res_cnt = 2'd1;
                end
                default:
                begin
                    res_cnt = 2'd0;
                end
            endcase
        end
        else
        begin
            case (stage_reg)
                ST_SEARCH:
                begin
                    if (is_start)
                    begin
                        stage_next = ST_ID;
                    end
                    else
                    begin
                        stage_next = ST_ERROR;
                        r0 = make_result(KIND_ID, 8'd0, 1'b0, 1'b0, 1'b0, STATUS_NO_START);
                        res_cnt = 2'd1;
                    end
                end
                ST_ID:
                begin
                    res_cnt = 2'd1;
                    if (char_in == CH_SPACE)
                    begin
                        r0 = make_result(KIND_ID, 8'd0, 1'b0, 1'b1, 1'b0, STATUS_OK);
                        stage_next = ST_INFO;
                    end
                    else
                    begin
                        r0 = make_result(KIND_ID, char_in, 1'b1, 1'b0, 1'b0, STATUS_OK);
                    end
                end
                ST_INFO:
                begin
                    res_cnt = 2'd1;
                    if (char_in == CH_NEWLINE)
                    begin
                        r0 = make_result(KIND_INFO, 8'd0, 1'b0, 1'b1, 1'b0, STATUS_OK);
                        stage_next = ST_CHECK;
                    end
                    else
                    begin
                        r0 = make_result(KIND_INFO, char_in, 1'b1, 1'b0, 1'b0, STATUS_OK);
                    end
                end
                ST_COMMENT:
                begin
                    res_cnt = 2'd1;
                    if (char_in == CH_NEWLINE)
                    begin
                        r0 = make_result(KIND_COMMENT, 8'd0, 1'b0, 1'b1, 1'b0, STATUS_OK);
                        stage_next = ST_CHECK;
                    end
                    else
                    begin
                        r0 = make_result(KIND_COMMENT, char_in, 1'b1, 1'b0, 1'b0,
                                         STATUS_OK);
                    end
                end
                ST_CHECK, ST_SEQ:
                begin
                    if (stage_reg == ST_CHECK && char_in == CH_SEMI)
                    begin
                        stage_next = ST_COMMENT;
                    end
                    else if (is_seq_byte(char_in))
                    begin
                        stage_next = ST_SEQ;
                        r0 = make_result(KIND_SEQ, char_in, 1'b1, 1'b0, 1'b0, STATUS_OK);
                        res_cnt = 2'd1;
                    end
                    else if (is_white(char_in))
                    begin
                        stage_next = ST_SEQ;
                    end
                    else
                    begin
                        // Close the record, then re-examine the byte as a record start
                        r0 = make_result(KIND_SEQ, 8'd0, 1'b0, 1'b1, 1'b1, STATUS_OK);
                        if (is_start)
                        begin
                            stage_next = ST_ID;
                            res_cnt    = 2'd1;
                        end
                        else
                        begin
                            stage_next = ST_ERROR;
                            r1 = make_result(KIND_ID, 8'd0, 1'b0, 1'b0, 1'b0,
                                             STATUS_NO_START);
                            res_cnt = 2'd2;
                        end
                    end
                end
                default:
                begin
                    stage_next = ST_ERROR;
                    r0 = make_result(KIND_ID, 8'd0, 1'b0, 1'b0, 1'b0, STATUS_NO_START);
                    res_cnt = 2'd1;
                end
            endcase
        end
    end

    // Mark the final result of the item
    always_comb
    begin
        res0      = r0;
        res1      = r1;
        res0.last = (res_cnt == 2'd1);
        res1.last = (res_cnt == 2'd2);
    end

    // Advance the stage on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_SEARCH;
        end
        else if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/frp_result_queue.sv
// Module: small result queue that takes up to two results and delivers one per cycle while popped.
`timescale 1ns / 1ps
`default_nettype none

module frp_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_cnt,
    input  wire frp_pkg::result_t  push0,
    input  wire frp_pkg::result_t  push1,
    input  wire logic              pop,
    output frp_pkg::result_t       head,
    output logic                   head_valid,
    output logic                   room_for_two
);
    import frp_pkg::*;

    result_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic [QPTR_W-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);
    assign head         = entry_reg[rd_ptr_reg];
    assign head_valid   = (count_reg != '0);
    assign room_for_two = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Update pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_cnt) - QCNT_W'(pop);
    end

    // Store new results
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/fasta_record_parser.sv
// Top level: FASTA record parser that labels a text stream byte by byte.
`timescale 1ns / 1ps
`default_nettype none

// The parser takes one FASTA text byte per cycle on in_chan and emits labeled
// results on out_chan: each content byte with its field kind (id, info,
// comment, sequence), plus field-end and record-end markers and a status code.
// A start byte met in search, the ';' of a comment line and whitespace inside a
// sequence give no result; a stray byte that closes a sequence may give two.
// An item with stream_end set closes any open record. A bad record start locks
// the parser into a sticky error state until reset. Each byte is classified
// combinationally by the stage machine and its results land in a four-entry
// result queue; in_chan accepts a byte every cycle while the queue has room
// for two results, so the sustained rate is one byte per cycle whenever each
// byte gives at most one result and the sink takes one result per cycle. A
// result appears on out_chan the cycle after its byte is accepted when the
// queue is empty, and later when it waits behind results already queued.
module fasta_record_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    frp_in_if.sink     in_chan,
    frp_out_if.source  out_chan
);
    import frp_pkg::*;

    result_t    res0;
    result_t    res1;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;
    logic       accept;
    logic       pop;
    result_t    head;
    logic       head_valid;
    logic       room_for_two;

    // Accept while the queue can take the worst-case two results
    assign in_chan.ready = room_for_two;
    assign accept        = in_chan.valid && room_for_two;
    assign push_cnt      = accept ? res_cnt : 2'd0;
    assign pop           = head_valid && out_chan.ready;

    frp_parse_fsm u_parse_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_in    (in_chan.char_in),
        .stream_end (in_chan.stream_end),
        .res0       (res0),
        .res1       (res1),
        .res_cnt    (res_cnt)
    );

    frp_result_queue u_result_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .push0        (res0),
        .push1        (res1),
        .pop          (pop),
        .head         (head),
        .head_valid   (head_valid),
        .room_for_two (room_for_two)
    );

    // Drive the result channel from the queue head
    assign out_chan.valid      = head_valid;
    assign out_chan.field_kind = head.field_kind;
    assign out_chan.char_out   = head.char_out;
    assign out_chan.char_valid = head.char_valid;
    assign out_chan.field_end  = head.field_end;
    assign out_chan.record_end = head.record_end;
    assign out_chan.status     = head.status;
    assign out_chan.last       = head.last;

endmodule

`default_nettype wire
